// ===== rtl/nwfi_pkg.sv =====
package nwfi_pkg;

    localparam int GRID_SIDE  = 32;
    localparam int MAX_POINTS = 16;
    localparam int MAX_VALUES = 32;

    localparam int CELL_W  = 5;
    localparam int POINT_W = 4;
    localparam int COL_W   = 5;
    localparam int WADDR_W = 2 * CELL_W + POINT_W;
    localparam int DADDR_W = POINT_W + COL_W;

    localparam int COORD_W = 16;
    localparam int VALUE_W = 16;
    localparam int NW_W    = 18;
    localparam int SUM_W   = 21;
    localparam int NUM_W   = 30;
    localparam int ACC_W   = 38;
    localparam int PROD_W  = NW_W + VALUE_W;
    localparam int RES_W   = 32;
    localparam int FRAC_W  = 14;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    localparam logic [1:0] KIND_WEIGHT = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam logic RK_WEIGHT = 1'b0;
    localparam logic RK_DATA   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERP = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CELL,
        S_SUM_RD,
        S_SUM_ACC,
        S_SUM_CHK,
        S_DIV_RD,
        S_DIV_LOAD,
        S_DIV_STEP,
        S_DIV_FIN,
        S_EMIT_W,
        S_MAC_RD,
        S_MAC_MUL,
        S_MAC_ACC,
        S_EMIT_D
    } t_state;

endpackage

// ===== rtl/normalized_weight_field_interpolator_core.sv =====
// Writes (weight or data entry) are taken while idle and do not stall; the block is ready again next cycle.
// Query: sums the weights of all points, then runs a serial restoring divide per point,
// then, when interpolation is on, the shared multiply-accumulate per point and column.
// Output back-pressure holds the emit states; the input stalls for the whole query, so one query at a time.
// Synchronous active-low reset clears control and sets configuration to its defaults; the weight and data
// memories and the normalized weights are not cleared and read undefined until written.
module normalized_weight_field_interpolator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [1:0]                           i_kind,
    input  logic [nwfi_pkg::COORD_W-1:0]         i_coord_x,
    input  logic [nwfi_pkg::COORD_W-1:0]         i_coord_y,
    input  logic [nwfi_pkg::CELL_W-1:0]          i_cell_x,
    input  logic [nwfi_pkg::CELL_W-1:0]          i_cell_y,
    input  logic [nwfi_pkg::POINT_W-1:0]         i_point,
    input  logic [nwfi_pkg::COL_W-1:0]           i_column,
    input  logic signed [nwfi_pkg::VALUE_W-1:0]  i_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_result_kind,
    output logic [4:0]                           o_index,
    output logic signed [nwfi_pkg::RES_W-1:0]    o_result_value,
    output logic                                 o_last,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [nwfi_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [nwfi_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import nwfi_pkg::*;

    // Storage: weight field and data table as synchronous-read memories.
    logic [VALUE_W-1:0] weight_mem [0:(1<<WADDR_W)-1];
    logic [VALUE_W-1:0] data_mem   [0:(1<<DADDR_W)-1];
    logic signed [NW_W-1:0] r_nw [0:MAX_POINTS-1];

    t_state r_state, n_state;

    // Configuration registers
    logic [5:0] r_cfg_cols, r_cfg_rows, r_cfg_values;
    logic [4:0] r_cfg_points;
    logic       r_cfg_interp;

    // Sequencer datapath
    logic [COORD_W-1:0]      r_qx, n_qx, r_qy, n_qy;
    logic [CELL_W-1:0]       r_cx, n_cx, r_cy, n_cy;
    logic [POINT_W-1:0]      r_i, n_i;
    logic [COL_W-1:0]        r_j, n_j;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [NUM_W-1:0]        r_num, n_num, r_quo, n_quo;
    logic [SUM_W-1:0]        r_rem, n_rem;
    logic [4:0]              r_cnt, n_cnt;
    logic                    r_neg, n_neg;
    logic signed [NW_W-1:0]  r_q, n_q;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic [VALUE_W-1:0]      r_wrd, r_drd;

    // Output register
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_kind, n_out_kind;
    logic [4:0]              r_out_index, n_out_index;
    logic signed [RES_W-1:0] r_out_value, n_out_value;
    logic                    r_out_last, n_out_last;

    logic in_xfer, out_free, nw_we;
    logic [5:0] cols_eff, rows_eff, nv_eff;
    logic [4:0] np_eff;
    logic [CELL_W-1:0] cell_x_q, cell_y_q;
    logic [POINT_W-1:0] last_pt;
    logic [COL_W-1:0]   last_col;
    logic [WADDR_W-1:0] w_raddr;
    logic [DADDR_W-1:0] d_raddr;
    logic [SUM_W-1:0]   dmag;
    logic [SUM_W-1:0]   trial;
    logic signed [NUM_W:0] qs;
    logic [VALUE_W-1:0] wmag;

    assign in_xfer     = i_valid && !o_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_stall;

    // Register clamps: zero grid size acts as one, oversize grids clamp to 32, zero or oversize use count means all.
    assign cols_eff = (r_cfg_cols == 6'd0) ? 6'd1 :
                      (r_cfg_cols > 6'(GRID_SIDE)) ? 6'(GRID_SIDE) : r_cfg_cols;
    assign rows_eff = (r_cfg_rows == 6'd0) ? 6'd1 :
                      (r_cfg_rows > 6'(GRID_SIDE)) ? 6'(GRID_SIDE) : r_cfg_rows;
    assign np_eff   = (r_cfg_points == 5'd0 || r_cfg_points > 5'(MAX_POINTS)) ?
                      5'(MAX_POINTS) : r_cfg_points;
    assign nv_eff   = (r_cfg_values == 6'd0 || r_cfg_values > 6'(MAX_VALUES)) ?
                      6'(MAX_VALUES) : r_cfg_values;
    assign last_pt  = POINT_W'(np_eff - 5'd1);
    assign last_col = COL_W'(nv_eff - 6'd1);

    // Cell index: floor(coord*(n-1)/65535). Split at bit 16, then one correction.
    function automatic logic [CELL_W-1:0] cell_of(input logic [COORD_W-1:0] c,
                                                  input logic [5:0] n);
        logic [20:0] p;
        logic [16:0] r;
        logic [CELL_W-1:0] q0;
        p  = c * 21'(n - 6'd1);
        q0 = p[20:16];
        r  = {1'b0, p[15:0]} + 17'(q0);
        cell_of = (r >= 17'd65535) ? q0 + 1'b1 : q0;
    endfunction

    assign cell_x_q = cell_of(r_qx, cols_eff);
    assign cell_y_q = cell_of(r_qy, rows_eff);

    assign w_raddr = {r_cy, r_cx, r_i};
    assign d_raddr = {r_i, r_j};
    assign dmag    = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign trial   = {r_rem[SUM_W-2:0], r_num[NUM_W-1]};
    assign wmag    = r_wrd[VALUE_W-1] ? VALUE_W'(-$signed(r_wrd)) : r_wrd;
    // r_q holds the finished weight throughout the emit state
    assign nw_we   = (r_state == S_EMIT_W);

    // Floor of the signed quotient: round magnitude down, step once more when negative
    // and inexact.
    assign qs = r_neg ? -$signed({1'b0, r_quo}) - $signed((NUM_W+1)'(r_rem != '0))
                      : $signed({1'b0, r_quo});

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_kind == KIND_WEIGHT) begin
            weight_mem[{i_cell_y, i_cell_x, i_point}] <= i_value;
        end
        r_wrd <= weight_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_kind == KIND_DATA) begin
            data_mem[{i_point, i_column}] <= i_value;
        end
        r_drd <= data_mem[d_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (nw_we) begin
            r_nw[r_i] <= r_q;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (in_xfer && i_kind == KIND_QUERY) n_state = S_CELL;
            S_CELL:     n_state = S_SUM_RD;
            S_SUM_RD:   n_state = S_SUM_ACC;
            S_SUM_ACC:  if (r_i == last_pt) n_state = S_SUM_CHK;
                        else n_state = S_SUM_RD;
            S_SUM_CHK:  if (r_sum == '0) n_state = S_IDLE;
                        else n_state = S_DIV_RD;
            S_DIV_RD:   n_state = S_DIV_LOAD;
            S_DIV_LOAD: n_state = S_DIV_STEP;
            S_DIV_STEP: if (r_cnt == 5'(NUM_W - 1)) n_state = S_DIV_FIN;
            S_DIV_FIN:  n_state = S_EMIT_W;
            S_EMIT_W: begin
                if (out_free) begin
                    if (r_i != last_pt) n_state = S_DIV_RD;
                    else if (r_cfg_interp) n_state = S_MAC_RD;
                    else n_state = S_IDLE;
                end
            end
            S_MAC_RD:   n_state = S_MAC_MUL;
            S_MAC_MUL:  n_state = S_MAC_ACC;
            S_MAC_ACC:  if (r_i == last_pt) n_state = S_EMIT_D;
                        else n_state = S_MAC_RD;
            S_EMIT_D: begin
                if (out_free) begin
                    if (r_j == last_col) n_state = S_IDLE;
                    else n_state = S_MAC_RD;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath and output register
    always_comb begin
        n_qx = r_qx;  n_qy = r_qy;  n_cx = r_cx;  n_cy = r_cy;
        n_i = r_i;    n_j = r_j;    n_sum = r_sum;
        n_num = r_num; n_quo = r_quo; n_rem = r_rem; n_cnt = r_cnt; n_neg = r_neg;
        n_q = r_q;    n_prod = r_prod; n_acc = r_acc;
        n_out_valid = r_out_valid && i_stall;
        n_out_kind  = r_out_kind;
        n_out_index = r_out_index;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        case (r_state)
            S_IDLE: begin
                n_qx = i_coord_x;
                n_qy = i_coord_y;
            end
            S_CELL: begin
                n_cx  = cell_x_q;
                n_cy  = cell_y_q;
                n_i   = '0;
                n_sum = '0;
            end
            S_SUM_ACC: begin
                n_sum = r_sum + SUM_W'($signed(r_wrd));
                n_i   = (r_i == last_pt) ? '0 : r_i + 1'b1;
            end
            S_DIV_LOAD: begin
                n_num = {wmag, {FRAC_W{1'b0}}};
                n_quo = '0;
                n_rem = '0;
                n_cnt = '0;
                n_neg = r_wrd[VALUE_W-1] ^ r_sum[SUM_W-1];
            end
            S_DIV_STEP: begin
                // One restoring step: shift in the next numerator bit, subtract if it fits.
                n_num = {r_num[NUM_W-2:0], 1'b0};
                if (trial >= dmag) begin
                    n_rem = trial - dmag;
                    n_quo = {r_quo[NUM_W-2:0], 1'b1};
                end else begin
                    n_rem = trial;
                    n_quo = {r_quo[NUM_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
            end
            S_DIV_FIN: begin
                if (qs > $signed((NUM_W+1)'(131071))) n_q = NW_W'(131071);
                else if (qs < -$signed((NUM_W+1)'(131072))) n_q = -NW_W'(131072);
                else n_q = NW_W'(qs);
            end
            S_EMIT_W: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = RK_WEIGHT;
                    n_out_index = 5'(r_i);
                    n_out_value = RES_W'(r_q);
                    n_out_last  = !r_cfg_interp && (r_i == last_pt);
                    if (r_i == last_pt) begin
                        n_i   = '0;
                        n_j   = '0;
                        n_acc = '0;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end
            end
            S_MAC_MUL: begin
                n_prod = r_nw[r_i] * $signed(r_drd);
            end
            S_MAC_ACC: begin
                n_acc = r_acc + ACC_W'(r_prod);
                n_i   = (r_i == last_pt) ? '0 : r_i + 1'b1;
            end
            S_EMIT_D: begin
                if (out_free) begin
                    // The shifted sum stays within 24 bits, so it never saturates at 32.
                    n_out_valid = 1'b1;
                    n_out_kind  = RK_DATA;
                    n_out_index = r_j;
                    n_out_value = RES_W'(r_acc >>> FRAC_W);
                    n_out_last  = (r_j == last_col);
                    n_acc       = '0;
                    n_j         = r_j + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_sum        <= '0;
            r_cfg_cols   <= 6'd32;
            r_cfg_rows   <= 6'd32;
            r_cfg_points <= 5'd16;
            r_cfg_values <= 6'd32;
            r_cfg_interp <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_sum       <= n_sum;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_COLS:   r_cfg_cols   <= i_cfg_data;
                    CFG_ROWS:   r_cfg_rows   <= i_cfg_data;
                    CFG_POINTS: r_cfg_points <= i_cfg_data[4:0];
                    CFG_VALUES: r_cfg_values <= i_cfg_data;
                    CFG_INTERP: r_cfg_interp <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers: hold without reset.
    always_ff @(posedge i_clk) begin
        r_qx <= n_qx;  r_qy <= n_qy;  r_cx <= n_cx;  r_cy <= n_cy;
        r_i <= n_i;    r_j <= n_j;
        r_num <= n_num; r_quo <= n_quo; r_rem <= n_rem; r_cnt <= n_cnt; r_neg <= n_neg;
        r_q <= n_q;    r_prod <= n_prod; r_acc <= n_acc;
        r_out_kind  <= n_out_kind;
        r_out_index <= n_out_index;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    assign o_valid        = r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_index        = r_out_index;
    assign o_result_value = r_out_value;
    assign o_last         = r_out_last;

endmodule

// ===== rtl/nwfi_checker.sv =====
module nwfi_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic [1:0]                    i_kind,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [nwfi_pkg::RES_W-1:0]    o_result_value
);
    import nwfi_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("output valid dropped while stalled");

    a_hold_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_result_value))
        else $error("output payload changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall && !o_valid) else $error("not idle after reset");

    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_kind != KIND_QUERY) |=> !o_stall)
        else $error("non-query transfer held the input");

endmodule

bind normalized_weight_field_interpolator_core nwfi_checker u_nwfi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_kind         (i_kind),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_result_value (o_result_value)
);
